FILE: design/erm_pkg.sv
// Shared types, constants and arithmetic helpers for the Euler angle to rotation matrix block.
// No dependencies; every other design file refers to this package by scoped names.
package erm_pkg;

  localparam int AngleW      = 16;
  localparam int MatW        = 16;
  localparam int AngleFrac   = 13;
  localparam int MatFrac     = 14;
  localparam int IntFrac     = 30;
  localparam int CordicSteps = 30;
  localparam int DataW       = 34;
  localparam int OutShift    = IntFrac - MatFrac;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic signed [DataW:0]   wide_t;
  typedef logic signed [MatW-1:0]  entry_t;

  localparam data_t PiQ30         = 34'sd3373259426;
  localparam data_t HalfPiQ30     = 34'sd1686629713;
  localparam data_t TwoPiQ30      = 34'sd6746518852;
  localparam data_t ThreeHalfPiQ30 = 34'sd5059889139;
  localparam data_t GainQ30       = 34'sd652032874;
  localparam entry_t OneOut       = entry_t'(1 << MatFrac);

  localparam data_t AtanTab [CordicSteps] = '{
    34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6, 34'sh03FEAB76,
    34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55, 34'sh003FFFEA, 34'sh001FFFFD,
    34'sh000FFFFF, 34'sh0007FFFF, 34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF,
    34'sh00007FFF, 34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
    34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F, 34'sh0000003F,
    34'sh0000001F, 34'sh0000000F, 34'sh00000008, 34'sh00000004, 34'sh00000002
  };

  typedef struct packed {
    logic signed [AngleW-1:0] roll_angle;
    logic signed [AngleW-1:0] pitch_angle;
    logic signed [AngleW-1:0] yaw_angle;
  } in_t;

  typedef struct packed {
    entry_t r00;
    entry_t r01;
    entry_t r02;
    entry_t r10;
    entry_t r11;
    entry_t r12;
    entry_t r20;
    entry_t r21;
    entry_t r22;
  } out_t;

  typedef struct packed {
    data_t z;
    logic  flip;
  } lane_t;

  typedef struct packed {
    lane_t roll;
    lane_t pitch;
    lane_t yaw;
  } item_t;

  typedef struct packed {
    data_t s;
    data_t c;
  } sc_t;

  function automatic data_t qmul(input data_t a, input data_t b);
    logic signed [2*DataW-1:0] p;
    p = (a * b) + ((2*DataW)'(1) <<< (IntFrac - 1));
    return p[IntFrac+DataW-1:IntFrac];
  endfunction

  function automatic wide_t widen(input data_t a);
    return wide_t'(a);
  endfunction

  function automatic entry_t to_out(input wide_t v);
    wide_t t;
    t = (v + (wide_t'(1) <<< (OutShift - 1))) >>> OutShift;
    if (t > wide_t'(OneOut)) begin
      return OneOut;
    end else if (t < -wide_t'(OneOut)) begin
      return -OneOut;
    end
    return t[MatW-1:0];
  endfunction

endpackage

FILE: design/euler_to_rotation_matrix_top.sv
// Euler angles (roll, pitch, yaw) to the rotation matrix Rz*Ry*Rx, fully pipelined.
// Depends on erm_pkg, erm_front, erm_queue, erm_cordic and erm_matrix.
// One angle beat can be started every cycle; busy stays low in normal operation. Each beat gives
// one result on valid_o after it passes through the 30-stage cordic
// pipeline plus fold, queue, sign, two product and one rounding stage. The receiver cannot stall,
// so results must be taken in the cycle valid_o is high.
module euler_to_rotation_matrix_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  erm_pkg::in_t  item_i,
  output logic          valid_o,
  output erm_pkg::out_t result_o
);

  logic           fr_valid, q_full, q_valid;
  erm_pkg::item_t fr_item, q_item;
  logic           cr_valid, cp_valid, cy_valid;
  erm_pkg::sc_t   roll_sc, pitch_sc, yaw_sc;

  assign busy = q_full;

  erm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (start && !busy),
    .item_i   (item_i),
    .valid_o  (fr_valid),
    .item_o   (fr_item)
  );

  erm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .item_i  (fr_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  erm_cordic u_roll (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(q_valid), .lane_i(q_item.roll),
    .valid_o(cr_valid), .sc_o(roll_sc)
  );

  erm_cordic u_pitch (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(q_valid), .lane_i(q_item.pitch),
    .valid_o(cp_valid), .sc_o(pitch_sc)
  );

  erm_cordic u_yaw (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(q_valid), .lane_i(q_item.yaw),
    .valid_o(cy_valid), .sc_o(yaw_sc)
  );

  erm_matrix u_matrix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (cr_valid && cp_valid && cy_valid),
    .roll_i   (roll_sc),
    .pitch_i  (pitch_sc),
    .yaw_i    (yaw_sc),
    .valid_o  (valid_o),
    .result_o (result_o)
  );

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cr_valid == cp_valid) && (cp_valid == cy_valid)) else $error("cordic lanes out of step");
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##36 valid_o) else $error("result missing");
  a_r00_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (result_o.r00 <= erm_pkg::OneOut && result_o.r00 >= -erm_pkg::OneOut))
    else $error("r00 out of range");
  a_r20_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (result_o.r20 <= erm_pkg::OneOut && result_o.r20 >= -erm_pkg::OneOut))
    else $error("r20 out of range");

endmodule

FILE: design/erm_front.sv
// Front end: accepts angle beats, scales them to Q4.30 and folds them into the cordic range.
// Depends on erm_pkg.
module erm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  erm_pkg::in_t  item_i,
  output logic          valid_o,
  output erm_pkg::item_t item_o
);

  function automatic erm_pkg::lane_t fold(input logic signed [erm_pkg::AngleW-1:0] a);
    erm_pkg::data_t z;
    erm_pkg::lane_t r;
    z = erm_pkg::data_t'(a) <<< (erm_pkg::IntFrac - erm_pkg::AngleFrac);
    r.flip = 1'b0;
    r.z    = z;
    if (z > erm_pkg::HalfPiQ30) begin
      if (z < erm_pkg::ThreeHalfPiQ30) begin
        r.z    = z - erm_pkg::PiQ30;
        r.flip = 1'b1;
      end else begin
        r.z = z - erm_pkg::TwoPiQ30;
      end
    end else if (z < -erm_pkg::HalfPiQ30) begin
      if (z > -erm_pkg::ThreeHalfPiQ30) begin
        r.z    = z + erm_pkg::PiQ30;
        r.flip = 1'b1;
      end else begin
        r.z = z + erm_pkg::TwoPiQ30;
      end
    end
    return r;
  endfunction

  logic           valid_q;
  erm_pkg::item_t item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q.roll  <= fold(item_i.roll_angle);
      item_q.pitch <= fold(item_i.pitch_angle);
      item_q.yaw   <= fold(item_i.yaw_angle);
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: design/erm_queue.sv
// Two-entry queue between the front end and the cordic back end.
// Depends on erm_pkg.
module erm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  erm_pkg::item_t item_i,
  output logic           full_o,
  output logic           valid_o,
  output erm_pkg::item_t item_o
);

  erm_pkg::item_t mem_q [2];
  logic           wr_q, wr_d, rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           pop, push;

  assign pop  = (cnt_q != 2'd0);
  assign push = push_i && (cnt_q != 2'd2);

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = pop;
  assign item_o  = mem_q[rd_q];

  // the back end drains every cycle, so the queue never holds two beats
  a_no_fill: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd2)
    else $error("queue filled up");
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push while full");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1 && !push_i) |=> cnt_q == 2'd0) else $error("queue did not drain");

endmodule

FILE: design/erm_cordic.sv
// Pipelined rotation-mode cordic, one stage per iteration, sine and cosine in Q4.30.
// Depends on erm_pkg.
module erm_cordic (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  erm_pkg::lane_t lane_i,
  output logic           valid_o,
  output erm_pkg::sc_t   sc_o
);

  localparam int N = erm_pkg::CordicSteps;

  erm_pkg::data_t x_q [N];
  erm_pkg::data_t y_q [N];
  erm_pkg::data_t z_q [N];
  logic           f_q [N];
  logic [N-1:0]   v_q;
  logic           vout_q;
  erm_pkg::sc_t   sc_q;

  for (genvar i = 0; i < N; i++) begin : g_stage
    erm_pkg::data_t xi, yi, zi;
    logic           fi, vi;
    if (i == 0) begin : g_first
      assign xi = erm_pkg::GainQ30;
      assign yi = '0;
      assign zi = lane_i.z;
      assign fi = lane_i.flip;
      assign vi = valid_i;
    end else begin : g_next
      assign xi = x_q[i-1];
      assign yi = y_q[i-1];
      assign zi = z_q[i-1];
      assign fi = f_q[i-1];
      assign vi = v_q[i-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else begin
        v_q[i] <= vi;
      end
    end

    always_ff @(posedge clk_i) begin
      if (!zi[erm_pkg::DataW-1]) begin
        x_q[i] <= xi - (yi >>> i);
        y_q[i] <= yi + (xi >>> i);
        z_q[i] <= zi - erm_pkg::AtanTab[i];
      end else begin
        x_q[i] <= xi + (yi >>> i);
        y_q[i] <= yi - (xi >>> i);
        z_q[i] <= zi + erm_pkg::AtanTab[i];
      end
      f_q[i] <= fi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else begin
      vout_q <= v_q[N-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sc_q.c <= f_q[N-1] ? -x_q[N-1] : x_q[N-1];
    sc_q.s <= f_q[N-1] ? -y_q[N-1] : y_q[N-1];
  end

  assign valid_o = vout_q;
  assign sc_o    = sc_q;

endmodule

FILE: design/erm_matrix.sv
// Back end products: forms the nine matrix entries from the three sine and cosine pairs.
// Depends on erm_pkg.
module erm_matrix (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  erm_pkg::sc_t roll_i,
  input  erm_pkg::sc_t pitch_i,
  input  erm_pkg::sc_t yaw_i,
  output logic         valid_o,
  output erm_pkg::out_t result_o
);

  logic [2:0] v_q;
  erm_pkg::data_t cpcy_q, cysp_q, crcy_q, srsy_q, cpsy_q, spsr_q, crsp_q, cysr_q;
  erm_pkg::data_t cpsr_q, cpcr_q, crsy_q, sp_a_q, sr_a_q, sy_a_q;
  erm_pkg::data_t cpcy_b_q, cpsy_b_q, cpsr_b_q, cpcr_b_q, crcy_b_q, srsy_b_q;
  erm_pkg::data_t crsy_b_q, cysr_b_q, sp_b_q;
  erm_pkg::data_t t01_q, t02_q, t11_q, t12_q;
  erm_pkg::out_t  res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  // first products
  always_ff @(posedge clk_i) begin
    cpcy_q <= erm_pkg::qmul(pitch_i.c, yaw_i.c);
    cysp_q <= erm_pkg::qmul(yaw_i.c, pitch_i.s);
    crcy_q <= erm_pkg::qmul(roll_i.c, yaw_i.c);
    srsy_q <= erm_pkg::qmul(roll_i.s, yaw_i.s);
    cpsy_q <= erm_pkg::qmul(pitch_i.c, yaw_i.s);
    spsr_q <= erm_pkg::qmul(pitch_i.s, roll_i.s);
    crsp_q <= erm_pkg::qmul(roll_i.c, pitch_i.s);
    cysr_q <= erm_pkg::qmul(yaw_i.c, roll_i.s);
    cpsr_q <= erm_pkg::qmul(pitch_i.c, roll_i.s);
    cpcr_q <= erm_pkg::qmul(pitch_i.c, roll_i.c);
    crsy_q <= erm_pkg::qmul(roll_i.c, yaw_i.s);
    sp_a_q <= pitch_i.s;
    sr_a_q <= roll_i.s;
    sy_a_q <= yaw_i.s;
  end

  // second products
  always_ff @(posedge clk_i) begin
    t01_q    <= erm_pkg::qmul(cysp_q, sr_a_q);
    t02_q    <= erm_pkg::qmul(crcy_q, sp_a_q);
    t11_q    <= erm_pkg::qmul(spsr_q, sy_a_q);
    t12_q    <= erm_pkg::qmul(crsp_q, sy_a_q);
    cpcy_b_q <= cpcy_q;
    cpsy_b_q <= cpsy_q;
    cpsr_b_q <= cpsr_q;
    cpcr_b_q <= cpcr_q;
    crcy_b_q <= crcy_q;
    srsy_b_q <= srsy_q;
    crsy_b_q <= crsy_q;
    cysr_b_q <= cysr_q;
    sp_b_q   <= sp_a_q;
  end

  // sums, rounding and saturation
  always_ff @(posedge clk_i) begin
    res_q.r00 <= erm_pkg::to_out(erm_pkg::widen(cpcy_b_q));
    res_q.r01 <= erm_pkg::to_out(erm_pkg::widen(t01_q) - erm_pkg::widen(crsy_b_q));
    res_q.r02 <= erm_pkg::to_out(erm_pkg::widen(t02_q) + erm_pkg::widen(srsy_b_q));
    res_q.r10 <= erm_pkg::to_out(erm_pkg::widen(cpsy_b_q));
    res_q.r11 <= erm_pkg::to_out(erm_pkg::widen(crcy_b_q) + erm_pkg::widen(t11_q));
    res_q.r12 <= erm_pkg::to_out(erm_pkg::widen(t12_q) - erm_pkg::widen(cysr_b_q));
    res_q.r20 <= erm_pkg::to_out(-erm_pkg::widen(sp_b_q));
    res_q.r21 <= erm_pkg::to_out(erm_pkg::widen(cpsr_b_q));
    res_q.r22 <= erm_pkg::to_out(erm_pkg::widen(cpcr_b_q));
  end

  assign valid_o  = v_q[2];
  assign result_o = res_q;

endmodule

FILE: test/euler_to_rotation_matrix_top_test.sv
// Testbench for euler_to_rotation_matrix_top: directed angle table, then random bursts.
// Results are checked field by field against a bit-exact cordic predictor; depends on erm_pkg.
module euler_to_rotation_matrix_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint PiQ = 64'sd3373259426;
  localparam longint HalfPiQ = 64'sd1686629713;
  localparam longint TwoPiQ = 64'sd6746518852;
  localparam longint GainQ = 64'sd652032874;
  localparam int MaxAngle = 25736;
  localparam int Latency = 36;
  localparam int NumRandom = 2000;
  localparam longint CycleLimit = 200000;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic               known;
    logic signed [15:0] r00;
    logic signed [15:0] r20;
    logic signed [15:0] r22;
  } vec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  erm_pkg::in_t item_i = '0;
  logic valid_o;
  erm_pkg::out_t result_o;

  erm_pkg::out_t matrix_q[$];
  int errors = 0;
  longint cycles = 0;
  longint atan_lut[30];
  vec_t vecs[$];

  euler_to_rotation_matrix_top u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .item_i(item_i),
    .valid_o(valid_o),
    .result_o(result_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    atan_lut = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
      64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};
  end

  function automatic longint q30_mul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic void sin_cos(input logic signed [15:0] ang, output longint s,
                                  output longint c);
    longint z, x, y, nx;
    logic flip;
    z = longint'(ang) * (64'sd1 <<< 17);
    x = GainQ;
    y = 0;
    flip = 1'b0;
    z = z % TwoPiQ;
    if (z > PiQ) z -= TwoPiQ;
    else if (z < -PiQ) z += TwoPiQ;
    if (z > HalfPiQ) begin
      z -= PiQ;
      flip = 1'b1;
    end else if (z < -HalfPiQ) begin
      z += PiQ;
      flip = 1'b1;
    end
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_lut[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_lut[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic signed [15:0] round_sat(longint v);
    longint t;
    t = (v + (64'sd1 <<< 15)) >>> 16;
    if (t > 16384) t = 16384;
    if (t < -16384) t = -16384;
    return t[15:0];
  endfunction

  function automatic erm_pkg::out_t rotation_of(erm_pkg::in_t a);
    longint sr, cr, sp, cp, sy, cy;
    erm_pkg::out_t m;
    sin_cos(a.roll_angle, sr, cr);
    sin_cos(a.pitch_angle, sp, cp);
    sin_cos(a.yaw_angle, sy, cy);
    m.r00 = round_sat(q30_mul(cp, cy));
    m.r01 = round_sat(q30_mul(q30_mul(cy, sp), sr) - q30_mul(cr, sy));
    m.r02 = round_sat(q30_mul(q30_mul(cr, cy), sp) + q30_mul(sr, sy));
    m.r10 = round_sat(q30_mul(cp, sy));
    m.r11 = round_sat(q30_mul(cr, cy) + q30_mul(q30_mul(sp, sr), sy));
    m.r12 = round_sat(q30_mul(q30_mul(cr, sp), sy) - q30_mul(cy, sr));
    m.r20 = round_sat(-sp);
    m.r21 = round_sat(q30_mul(cp, sr));
    m.r22 = round_sat(q30_mul(cp, cr));
    return m;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic send_beat(erm_pkg::in_t a);
    start <= 1'b1;
    item_i <= a;
    matrix_q.push_back(rotation_of(a));
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] pick_angle();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'($urandom);
    if (r == 1) return 16'(MaxAngle - int'($urandom_range(0, 3)));
    if (r == 2) return 16'(-MaxAngle + int'($urandom_range(0, 3)));
    if (r == 3) return 16'(12868 + int'($urandom_range(0, 4)) - 2);
    return 16'(int'($urandom_range(0, 2 * MaxAngle)) - MaxAngle);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** euler_to_rotation_matrix_top: FAILED **");
      $finish;
    end
    if (rst_ni && valid_o) begin
      if (matrix_q.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        erm_pkg::out_t w;
        w = matrix_q.pop_front();
        if (result_o.r00 !== w.r00) report_mismatch("r00", result_o.r00, w.r00);
        if (result_o.r01 !== w.r01) report_mismatch("r01", result_o.r01, w.r01);
        if (result_o.r02 !== w.r02) report_mismatch("r02", result_o.r02, w.r02);
        if (result_o.r10 !== w.r10) report_mismatch("r10", result_o.r10, w.r10);
        if (result_o.r11 !== w.r11) report_mismatch("r11", result_o.r11, w.r11);
        if (result_o.r12 !== w.r12) report_mismatch("r12", result_o.r12, w.r12);
        if (result_o.r20 !== w.r20) report_mismatch("r20", result_o.r20, w.r20);
        if (result_o.r21 !== w.r21) report_mismatch("r21", result_o.r21, w.r21);
        if (result_o.r22 !== w.r22) report_mismatch("r22", result_o.r22, w.r22);
      end
    end
  end

  initial begin
    erm_pkg::in_t a;
    erm_pkg::out_t m;
    int gap;
    int burst;
    int wait_n;
    // zero, extremes, quarter turns, wrap beyond pi and full-range codes
    vecs = '{
      '{16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd16384, 16'sd0, 16'sd16384},
      '{16'sd25736, 16'sd0, 16'sd0, 1'b0, 0, 0, 0},
      '{-16'sd25736, 16'sd0, 16'sd0, 1'b0, 0, 0, 0},
      '{16'sd0, 16'sd25736, 16'sd0, 1'b0, 0, 0, 0},
      '{16'sd0, -16'sd25736, 16'sd0, 1'b0, 0, 0, 0},
      '{16'sd0, 16'sd0, 16'sd25736, 1'b0, 0, 0, 0},
      '{16'sd0, 16'sd0, -16'sd25736, 1'b0, 0, 0, 0},
      '{16'sd12868, 16'sd12868, 16'sd12868, 1'b0, 0, 0, 0},
      '{-16'sd12868, -16'sd12868, -16'sd12868, 1'b0, 0, 0, 0},
      '{16'sd12869, 16'sd12867, -16'sd12869, 1'b0, 0, 0, 0},
      '{16'sd25737, -16'sd25737, 16'sd25740, 1'b0, 0, 0, 0},
      '{16'sd32767, -16'sd32768, 16'sd32767, 1'b0, 0, 0, 0},
      '{-16'sd32768, 16'sd32767, -16'sd32768, 1'b0, 0, 0, 0},
      '{-16'sd1, 16'sd1, -16'sd1, 1'b0, 0, 0, 0},
      '{16'sd4289, 16'sd8579, -16'sd6434, 1'b0, 0, 0, 0},
      '{16'sd21450, -16'sd17160, 16'sd19000, 1'b0, 0, 0, 0}};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (vecs[i]) begin
      a.roll_angle = vecs[i].roll;
      a.pitch_angle = vecs[i].pitch;
      a.yaw_angle = vecs[i].yaw;
      if (vecs[i].known) begin
        m = rotation_of(a);
        if (m.r00 !== vecs[i].r00 || m.r20 !== vecs[i].r20 || m.r22 !== vecs[i].r22)
          report_mismatch("identity prediction", m.r00, vecs[i].r00);
      end
      send_beat(a);
    end
    for (int n = 0; n < NumRandom; n += burst) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) begin
        a.roll_angle = pick_angle();
        a.pitch_angle = pick_angle();
        a.yaw_angle = pick_angle();
        send_beat(a);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    start <= 1'b0;
    wait_n = 0;
    while (matrix_q.size() != 0 && wait_n < 1000) begin
      @(posedge clk_i);
      wait_n++;
    end
    repeat (Latency + 4) @(posedge clk_i);
    if (errors == 0 && matrix_q.size() == 0) begin
      $display("** euler_to_rotation_matrix_top: PASSED **");
    end else begin
      $display("** euler_to_rotation_matrix_top: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/erm_pkg.sv
design/erm_front.sv
design/erm_queue.sv
design/erm_cordic.sv
design/erm_matrix.sv
design/euler_to_rotation_matrix_top.sv
test/euler_to_rotation_matrix_top_test.sv
